// File: rtl/core/bps_pkg.sv
// bps_pkg: shared types and constants for the byte pattern search block.
// Used by every module under rtl/core; no dependencies.

package bps_pkg;

    localparam int DEFAULT_MAX_PATTERN = 16;

    // pattern bytes held in the two 64-bit pattern registers
    localparam int PAT_BYTES = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PLEN_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic found;
        logic buffer_short;
    } verdict_t;

    typedef struct packed {
        logic [PLEN_W-1:0]     pattern_length;
        logic [CFG_DATA_W-1:0] pattern_low_bytes;
        logic [CFG_DATA_W-1:0] pattern_high_bytes;
    } pattern_cfg_t;

endpackage

// File: rtl/core/bps_cfg_regs.sv
// bps_cfg_regs: configuration register file (pattern length and bytes).
// Depends on bps_pkg.

module bps_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
    output bps_pkg::pattern_cfg_t          pattern_cfg
);
    import bps_pkg::*;

    pattern_cfg_t cfg_reg;
    pattern_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign pattern_cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[PLEN_W-1:0];
                REG_PATTERN_LOW:    cfg_next.pattern_low_bytes = cfg_data;
                REG_PATTERN_HIGH:   cfg_next.pattern_high_bytes = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/bps_input_stage.sv
// bps_input_stage: input register holding one item ahead of the matcher.
// Depends on bps_pkg.

module bps_input_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bps_pkg::item_t s_item,
    input  logic           out_free,
    output logic           advance,
    output bps_pkg::item_t item
);
    import bps_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // only an item carrying last needs room in the result register
    assign advance = valid_reg && (!item_reg.last || out_free);
    assign s_ready = !valid_reg || advance;
    assign item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: rtl/core/bps_matcher.sv
// bps_matcher: byte window, saturating byte count, sticky hit flag and the
// parallel compare of the newest bytes against the pattern. Depends on bps_pkg.

module bps_matcher #(
    parameter int MAX_PATTERN = bps_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  bps_pkg::item_t        item,
    input  bps_pkg::pattern_cfg_t pattern_cfg,
    output bps_pkg::verdict_t     verdict
);
    import bps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int CMP_W = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0] SEEN_MAX = LEN_W'(MAX_PATTERN);

    logic [7:0]       win_reg [WIN_D];
    logic [LEN_W-1:0] seen_reg;
    logic [LEN_W-1:0] seen_next;
    logic             hit_reg;
    logic             hit_next;

    logic [CMP_W-1:0] len_wide;
    logic [LEN_W-1:0] eff_len;
    logic [7:0]       pat      [MAX_PATTERN];
    logic [7:0]       got      [MAX_PATTERN];
    logic [7:0]       pat_algn [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pos_ok;
    logic             all_eq;

    assign len_wide = CMP_W'(pattern_cfg.pattern_length);
    assign eff_len = (len_wide > MAX_LEN) ? SEEN_MAX : LEN_W'(len_wide);

    // pattern bytes past the two registers read as zero
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
        if (j < 8) begin : g_low
            assign pat[j] = pattern_cfg.pattern_low_bytes[8*j +: 8];
        end else if (j < PAT_BYTES) begin : g_high
            assign pat[j] = pattern_cfg.pattern_high_bytes[8*(j-8) +: 8];
        end else begin : g_zero
            assign pat[j] = 8'h00;
        end
    end

    // got[k] is the byte k places back from the newest one
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_got
        if (k == 0) begin : g_new
            assign got[k] = item.data_byte;
        end else begin : g_old
            assign got[k] = win_reg[k-1];
        end
    end

    // pattern byte j lines up with position len-1-j
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_algn[k] = 8'h00;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (int'(eff_len) == j + k + 1) begin
                    pat_algn[k] = pat[j];
                end
            end
            pos_ok[k] = (k >= int'(eff_len)) || (got[k] == pat_algn[k]);
        end
    end

    assign all_eq = &pos_ok;

    always_comb begin
        seen_next = seen_reg;
        hit_next = hit_reg;
        if (item.has_byte) begin
            if (seen_reg != SEEN_MAX) begin
                seen_next = seen_reg + 1'b1;
            end
            if (eff_len != '0 && seen_next >= eff_len && all_eq) begin
                hit_next = 1'b1;
            end
        end
    end

    assign verdict.found = (eff_len != '0) && hit_next;
    assign verdict.buffer_short = seen_next < eff_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            hit_reg <= 1'b0;
        end else if (advance) begin
            if (item.last) begin
                seen_reg <= '0;
                hit_reg <= 1'b0;
            end else begin
                seen_reg <= seen_next;
                hit_reg <= hit_next;
            end
        end
    end

    // window bytes are only compared once the count covers them: no reset
    always_ff @(posedge aclk) begin
        if (advance && item.has_byte) begin
            win_reg[0] <= item.data_byte;
            for (int i = 1; i < WIN_D; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

endmodule

// File: rtl/core/byte_pattern_search.sv
// byte_pattern_search: top level of the streaming byte pattern search.
// Depends on bps_pkg, bps_cfg_regs, bps_input_stage and bps_matcher.
//
// Usage: write pattern_length (index 0), pattern bytes 0-7 (index 1) and
// pattern bytes 8-15 (index 2) over the cfg_ channel while the block is idle;
// the channel is always ready. Stream the buffer one byte per s_ transaction,
// s_has_byte marking a real byte and s_last closing the buffer. A buffer may
// be empty: a single transaction with s_last set and s_has_byte clear.
// Only the transaction carrying s_last gives a result on m_: m_found says
// the pattern occurred anywhere in the buffer, m_buffer_short that the
// buffer held fewer bytes than the pattern. A zero length never matches.
// Throughput is one byte per cycle but for the stall below. The last item is
// held in the input register, then its verdict in the result register, set by
// the single compare of the newest bytes against all pattern bytes.
// A stalled result register holds only items with s_last; plain bytes keep
// flowing until a second verdict is waiting behind it.
// Reset clears the pattern registers, the byte count and the hit flag, and
// leaves both channels empty. After each verdict the buffer state restarts.

module byte_pattern_search #(
    parameter int MAX_PATTERN = bps_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic                           s_has_byte,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic                           m_buffer_short
);
    import bps_pkg::*;

    pattern_cfg_t pattern_cfg;
    item_t        s_item;
    item_t        item;
    logic         advance;
    logic         out_free;
    verdict_t     verdict;

    logic         m_valid_reg;
    verdict_t     result_reg;

    assign s_item = '{data_byte: s_data_byte, has_byte: s_has_byte, last: s_last};

    bps_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pattern_cfg (pattern_cfg)
    );

    bps_input_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    bps_matcher #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (item),
        .pattern_cfg (pattern_cfg),
        .verdict     (verdict)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && item.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item.last) begin
            result_reg <= verdict;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_found = result_reg.found;
    assign m_buffer_short = result_reg.buffer_short;

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for byte_pattern_search.
// Depends on bps_pkg and the RTL under rtl/core; predicts each verdict from its own
// model of the search window and checks it against the m_ channel.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam int SEARCH_MAX = DEFAULT_MAX_PATTERN;
    localparam int ITEM_GOAL  = 1700;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte    = '0;
    logic                  s_has_byte     = 1'b0;
    logic                  s_last         = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_found;
    logic                  m_buffer_short;

    byte_pattern_search dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_has_byte     (s_has_byte),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_buffer_short (m_buffer_short)
    );

    // predicted configuration and buffer state
    logic [PLEN_W-1:0]     pat_len = '0;
    logic [CFG_DATA_W-1:0] pat_lo  = '0;
    logic [CFG_DATA_W-1:0] pat_hi  = '0;
    logic [7:0]            recent [0:SEARCH_MAX-2];
    int                    seen_count = 0;
    bit                    hit_flag   = 1'b0;

    item_t    pending_items [$];
    verdict_t verdicts_due  [$];
    item_t    next_item;
    verdict_t want;

    int unsigned send_gap     = 0;
    int unsigned recv_wait    = 0;
    int unsigned recv_draw;
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    int          verdict_errors = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        foreach (recent[i]) recent[i] = '0;
    end

    function automatic int active_length();
        return (pat_len > SEARCH_MAX) ? SEARCH_MAX : int'(pat_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int j);
        if (j < 8)
            return pat_lo[8*j +: 8];
        return pat_hi[8*(j-8) +: 8];
    endfunction

    // one accepted transaction through the search model
    function automatic void search_step(input logic [7:0] b, input logic hb, input logic lst);
        int         n;
        bit         hit_now;
        logic [7:0] got;
        verdict_t   v;
        n = active_length();
        if (hb) begin
            if (seen_count < SEARCH_MAX)
                seen_count++;
            if (n > 0 && seen_count >= n) begin
                hit_now = 1'b1;
                for (int j = 0; j < n; j++) begin
                    got = (n - 1 - j == 0) ? b : recent[n-2-j];
                    if (got != pattern_byte(j))
                        hit_now = 1'b0;
                end
                if (hit_now)
                    hit_flag = 1'b1;
            end
            for (int i = SEARCH_MAX - 2; i > 0; i--)
                recent[i] = recent[i-1];
            recent[0] = b;
        end
        if (lst) begin
            v.found        = (n > 0) && hit_flag;
            v.buffer_short = seen_count < n;
            verdicts_due.insert(verdicts_due.size(), v);
            seen_count = 0;
            hit_flag   = 1'b0;
            foreach (recent[i]) recent[i] = '0;
        end
    endfunction

    function automatic void push_item(input logic [7:0] b, input logic hb, input logic lst);
        item_t it;
        it.data_byte = b;
        it.has_byte  = hb;
        it.last      = lst;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [63:0] pattern_word(input bit narrow);
        logic [63:0] w;
        logic [7:0]  alphabet [0:3];
        alphabet = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        for (int k = 0; k < 8; k++)
            w[8*k +: 8] = narrow ? alphabet[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
        return w;
    endfunction

    // one random buffer, often holding the pattern or a near miss; returns its item count
    function automatic int queue_buffer();
        logic [7:0] bytes_out [0:47];
        int         n, nbytes, pos, flip, r, counted;
        bit         tail_empty;
        n = active_length();
        r = $urandom_range(0, 9);
        if (r == 0)
            nbytes = $urandom_range(0, 3);
        else if (r < 8)
            nbytes = $urandom_range((n > 2) ? n - 2 : 0, n + 10);
        else
            nbytes = $urandom_range(0, 47);
        for (int i = 0; i < nbytes; i++)
            bytes_out[i] = (n > 0 && $urandom_range(0, 1) == 0) ?
                pattern_byte($urandom_range(0, n - 1)) : 8'($urandom_range(0, 255));
        if (n > 0 && nbytes >= n && $urandom_range(0, 3) != 0) begin
            pos = $urandom_range(0, nbytes - n);
            for (int j = 0; j < n; j++)
                bytes_out[pos+j] = pattern_byte(j);
            if ($urandom_range(0, 2) == 0) begin
                flip = pos + $urandom_range(0, n - 1);
                bytes_out[flip] = bytes_out[flip] ^ (8'd1 << $urandom_range(0, 7));
            end
        end
        tail_empty = ($urandom_range(0, 7) == 0);
        counted = 0;
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                counted++;
            end
            push_item(bytes_out[i], 1'b1, (i == nbytes - 1) && !tail_empty);
            counted++;
        end
        if (nbytes == 0 || tail_empty) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            counted++;
        end
        return counted;
    endfunction

    // sender stalls until every verdict is in and the pipeline has emptied
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_PATTERN_LENGTH: pat_len = val[PLEN_W-1:0];
            REG_PATTERN_LOW:    pat_lo  = val;
            REG_PATTERN_HIGH:   pat_hi  = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                search_step(s_data_byte, s_has_byte, s_last);
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_data_byte <= next_item.data_byte;
                    s_has_byte  <= next_item.has_byte;
                    s_last      <= next_item.last;
                    s_valid     <= 1'b1;
                    if ($urandom_range(0, 47) == 0)
                        send_idle_on = !send_idle_on;
                    send_gap <= send_idle_on ? $urandom_range(0, 13) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                verdict_errors++;
                if (verdict_errors <= 10)
                    $display("unexpected verdict transaction: found=%0b short=%0b",
                             m_found, m_buffer_short);
            end else begin
                want = verdicts_due.pop_front();
                if (m_found !== want.found || m_buffer_short !== want.buffer_short) begin
                    verdict_errors++;
                    if (verdict_errors <= 10)
                        $display("verdict mismatch: found exp %0b got %0b, short exp %0b got %0b",
                                 want.found, m_found, want.buffer_short, m_buffer_short);
                end
            end
            if ($urandom_range(0, 31) == 0)
                recv_idle_on = !recv_idle_on;
            recv_draw = recv_idle_on ? $urandom_range(0, 13) : 0;
            recv_wait <= recv_draw;
            m_ready   <= (recv_draw == 0);
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            m_ready   <= (recv_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int items_sent;
        int target;
        int phase;
        int len;
        bit narrow;
        items_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero length after reset, then an empty buffer
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h3C, 1'b0, 1'b1);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_005A_FF00);
        write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        // hit on the closing byte, short buffer, gaps of invalid bytes, empty buffer
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h77, 1'b0, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(8'h5A, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);
        // length changed part way through a buffer
        push_item(8'h00, 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd16);
        push_item(8'hFF, 1'b1, 1'b1);
        wait_idle();
        // length beyond the pattern store is clipped
        write_reg(REG_PATTERN_LENGTH, 64'd31);
        push_item(8'h5A, 1'b1, 1'b1);

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            wait_idle();
            case (phase)
                0: len = 16;
                1: len = 31;
                2: len = 1;
                3: len = 0;
                4: len = 17;
                default: begin
                    if ($urandom_range(0, 7) == 0)
                        len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
                    else
                        len = $urandom_range(1, 16);
                end
            endcase
            narrow = ($urandom_range(0, 2) != 0);
            write_reg(REG_PATTERN_LENGTH, 64'(len));
            if (phase < 5 || $urandom_range(0, 3) != 0)
                write_reg(REG_PATTERN_LOW, pattern_word(narrow));
            if (phase < 5 || $urandom_range(0, 3) != 0)
                write_reg(REG_PATTERN_HIGH, pattern_word(narrow));
            target = items_sent + $urandom_range(80, 200);
            while (items_sent < target)
                items_sent += queue_buffer();
            // sometimes leave a buffer open across the next register change
            if ($urandom_range(0, 2) == 0) begin
                for (int k = $urandom_range(1, 5); k > 0; k--) begin
                    push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                    items_sent++;
                end
            end
            phase++;
        end
        // close any buffer left open
        push_item(8'h00, 1'b0, 1'b1);
        wait_idle();

        if (verdict_errors == 0 && verdicts_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
